// ----- hdl/mcc_pkg.sv -----
package mcc_pkg;

	localparam int MAX_MATRICES = 32;
	localparam int DIM_BITS     = 16;
	localparam int DIM_FIELD_W  = 16;
	localparam int COST_W       = 62;
	localparam int OUT_DATA_W   = ((COST_W + 7) / 8) * 8;

	localparam int DEPTH        = MAX_MATRICES + 1;
	localparam int DADDR_W      = $clog2(DEPTH);
	localparam int CNT_W        = $clog2(DEPTH + 1);
	localparam int IDX_W        = $clog2(MAX_MATRICES);
	localparam int CDEPTH       = MAX_MATRICES * MAX_MATRICES;
	localparam int CADDR_W      = $clog2(CDEPTH);
	localparam int PROD1_W      = 2 * DIM_BITS;
	localparam int PROD2_W      = 3 * DIM_BITS;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_SHORT = 2'd1,
		STAT_LONG  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_RD_DI,
		ST_RD_DJ,
		ST_RD_L,
		ST_RD_R,
		ST_MUL,
		ST_ACC,
		ST_EMIT
	} state_t;

	function automatic logic [CADDR_W-1:0] cost_addr(input logic [IDX_W-1:0] row,
		input logic [IDX_W-1:0] col);
		return CADDR_W'(row) * CADDR_W'(MAX_MATRICES) + CADDR_W'(col);
	endfunction

	function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
		input logic [COST_W-1:0] b);
		logic [COST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COST_W] ? COST_MAX : s[COST_W-1:0];
	endfunction

endpackage

// ----- hdl/matrix_chain_order_cost.sv -----
// Matrix chain order cost.
// Input stream: one matrix dimension per transaction on s_tdata, s_tlast set on
// the final dimension. n dimensions describe n-1 matrices.
// Output stream: one transaction per chain, on the transaction after s_tlast:
// m_tdata carries the least scalar multiplication count (saturating), m_tuser
// the status (ok, fewer than two dimensions, more than the store holds).
// Loading accepts one dimension per cycle. After the last dimension the block
// runs the interval program out of two RAMs (dimensions, span costs): each
// span first reads its two end dimensions, then each split point steps through
// left read, right read, multiply and compare. Error chains and single
// matrices go from loading straight to the emit state.
// s_tready is low from the accepted s_tlast until the result sits in the
// output register; a result waiting on m_tready does not block loading of
// the next chain, only the hand-off of its result.
// Reset clears the counters, the sequencer and the output valid; the RAMs
// need no clearing since every entry whose read value is used is written earlier in the run.
module matrix_chain_order_cost (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [mcc_pkg::DIM_FIELD_W-1:0] s_tdata,  // dim
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mcc_pkg::OUT_DATA_W-1:0]  m_tdata,  // min_cost, zero pad
	output logic [1:0]                      m_tuser   // status
);
	import mcc_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]    count_q, cnt_after, mats_q, len_q, jp1_c;
	logic                ovf_q, ovf_after, room;
	logic [IDX_W-1:0]    i_q, j_q, k_q, kp1;
	logic                in_acc, last_k, emit_go;
	status_t             status_new, status_q, out_status_q;

	logic [DIM_BITS-1:0] dim_in, di_q, dj_q, dim_rdata;
	logic [PROD1_W-1:0]  p1_q;
	logic [PROD2_W-1:0]  p2_q;
	logic [COST_W-1:0]   left_q, sum_q, best_q, result_q, out_cost_q;
	logic [COST_W-1:0]   cost_rdata, c_val, best_new;

	logic                dim_we, dim_re, cost_re, cost_we;
	logic [DADDR_W-1:0]  dim_raddr;
	logic [CADDR_W-1:0]  cost_raddr;

	assign s_tready  = (state_q == ST_LOAD);
	assign in_acc    = s_tvalid && s_tready;
	assign dim_in    = DIM_BITS'(s_tdata);
	assign room      = (count_q < CNT_W'(DEPTH));
	assign cnt_after = room ? count_q + CNT_W'(1) : count_q;
	assign ovf_after = ovf_q | ~room;
	assign dim_we    = in_acc && room;

	always_comb begin
		if (ovf_after) begin
			status_new = STAT_LONG;
		end else if (cnt_after < CNT_W'(2)) begin
			status_new = STAT_SHORT;
		end else begin
			status_new = STAT_OK;
		end
	end

	assign kp1     = k_q + IDX_W'(1);
	assign last_k  = (kp1 == j_q);
	assign jp1_c   = CNT_W'(j_q) + CNT_W'(1);
	assign emit_go = !m_tvalid || m_tready;

	assign c_val    = sat_add(sum_q, COST_W'(p2_q));
	assign best_new = (c_val < best_q) ? c_val : best_q;

	mcc_ram #(
		.WIDTH(DIM_BITS),
		.DEPTH(DEPTH)
	) u_dim_ram (
		.clk  (clk),
		.we   (dim_we),
		.waddr(count_q[DADDR_W-1:0]),
		.wdata(dim_in),
		.re   (dim_re),
		.raddr(dim_raddr),
		.rdata(dim_rdata)
	);

	mcc_ram #(
		.WIDTH(COST_W),
		.DEPTH(CDEPTH)
	) u_cost_ram (
		.clk  (clk),
		.we   (cost_we),
		.waddr(cost_addr(i_q, j_q)),
		.wdata(best_new),
		.re   (cost_re),
		.raddr(cost_raddr),
		.rdata(cost_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Spans are visited by growing length; every cost value used belongs to a shorter
	// span written in an earlier pass, so no forwarding is needed.
	always_comb begin
		state_d    = state_q;
		dim_re     = 1'b0;
		dim_raddr  = '0;
		cost_re    = 1'b0;
		cost_raddr = '0;
		cost_we    = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && s_tlast) begin
					if (status_new != STAT_OK || cnt_after == CNT_W'(2)) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_RD_DI;
					end
				end
			end
			ST_RD_DI: begin
				dim_re    = 1'b1;
				dim_raddr = DADDR_W'(i_q);
				state_d   = ST_RD_DJ;
			end
			ST_RD_DJ: begin
				dim_re    = 1'b1;
				dim_raddr = DADDR_W'(j_q) + DADDR_W'(1);
				state_d   = ST_RD_L;
			end
			ST_RD_L: begin
				cost_re    = 1'b1;
				cost_raddr = cost_addr(i_q, k_q);
				dim_re     = 1'b1;
				dim_raddr  = DADDR_W'(k_q) + DADDR_W'(1);
				state_d    = ST_RD_R;
			end
			ST_RD_R: begin
				cost_re    = 1'b1;
				cost_raddr = cost_addr(kp1, j_q);
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				if (last_k) begin
					cost_we = 1'b1;
					if (jp1_c >= mats_q && len_q == mats_q) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_RD_DI;
					end
				end else begin
					state_d = ST_RD_L;
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			len_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (in_acc) begin
				if (s_tlast) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
					len_q   <= CNT_W'(2);
					i_q     <= '0;
					j_q     <= IDX_W'(1);
				end else begin
					count_q <= cnt_after;
					ovf_q   <= ovf_after;
				end
			end
			if (state_q == ST_RD_DJ) begin
				k_q <= i_q;
			end
			if (state_q == ST_ACC) begin
				if (last_k) begin
					// advance to the next span, or to the next length
					if (jp1_c < mats_q) begin
						i_q <= i_q + IDX_W'(1);
						j_q <= j_q + IDX_W'(1);
					end else if (len_q != mats_q) begin
						len_q <= len_q + CNT_W'(1);
						i_q   <= '0;
						j_q   <= len_q[IDX_W-1:0];
					end
				end else begin
					k_q <= kp1;
				end
			end
			if (state_q == ST_EMIT && emit_go) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && s_tlast) begin
			status_q <= status_new;
			mats_q   <= cnt_after - CNT_W'(1);
			result_q <= '0;
		end
		if (state_q == ST_RD_DJ) begin
			di_q   <= dim_rdata;
			best_q <= COST_MAX;
		end
		// on the first split the dim read still holds the right span end
		if (state_q == ST_RD_L && k_q == i_q) begin
			dj_q <= dim_rdata;
		end
		if (state_q == ST_RD_R) begin
			left_q <= (k_q == i_q) ? '0 : cost_rdata;
			p1_q   <= PROD1_W'(di_q) * PROD1_W'(dim_rdata);
		end
		if (state_q == ST_MUL) begin
			sum_q <= sat_add(left_q, last_k ? '0 : cost_rdata);
			p2_q  <= PROD2_W'(p1_q) * PROD2_W'(dj_q);
		end
		if (state_q == ST_ACC) begin
			best_q <= best_new;
			if (last_k) begin
				result_q <= best_new;
			end
		end
		if (state_q == ST_EMIT && emit_go) begin
			out_cost_q   <= result_q;
			out_status_q <= status_q;
		end
	end

	assign m_tdata = OUT_DATA_W'(out_cost_q);
	assign m_tuser = out_status_q;

endmodule

// ----- hdl/mcc_ram.sv -----
module mcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/mcc_checker.sv -----
module mcc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            s_tlast,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [mcc_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic [1:0]                      m_tuser
);
	import mcc_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// error status carries no cost
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STAT_OK |-> m_tdata == '0)
		else $error("error result with nonzero cost");

	// input closes after the last dimension of a chain
	a_close_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input still open after last transaction");

	// input closes only after a last dimension
	a_close_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid && s_tlast))
		else $error("input closed without a last transaction");

endmodule

bind matrix_chain_order_cost mcc_checker u_mcc_checker (.*);
